### hw/rtl/brms_pkg.sv
// Shared types, constants and decode functions of the banked register file.
// No dependencies.
package brms_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [2:0] OpWrStatus = 3'd0;
  localparam logic [2:0] OpRaise    = 3'd1;
  localparam logic [2:0] OpReturn   = 3'd2;
  localparam logic [2:0] OpRdReg    = 3'd3;
  localparam logic [2:0] OpWrReg    = 3'd4;

  localparam logic [2:0] ExcReserved = 3'd5;
  localparam logic [2:0] BankNone    = 3'd7;
  localparam logic [2:0] BankUsr     = 3'd0;
  localparam logic [2:0] BankFiq     = 3'd1;

  localparam logic [DataW-1:0] ThumbBit   = 32'h20;
  localparam logic [DataW-1:0] ModeBit4   = 32'h10;
  localparam logic [DataW-1:0] ModeClear  = 32'hFFFF_FFF0;
  localparam logic [DataW-1:0] StatusRst  = 32'hD3;
  localparam logic [4:0]       SpsrIndex  = 5'd16;

  // Command from controller to datapath
  typedef struct packed {
    logic          load;     // take one event this cycle
    logic [2:0]    op;
    logic [DataW-1:0] value;
    logic [2:0]    exc_type;
    logic [4:0]    reg_index;
  } brms_cmd_t;

  // Mode nibble to bank number
  function automatic logic [2:0] bank_of_mode(input logic [3:0] m);
    case (m)
      4'd0, 4'd15: bank_of_mode = 3'd0;
      4'd1:        bank_of_mode = 3'd1;
      4'd2:        bank_of_mode = 3'd2;
      4'd3:        bank_of_mode = 3'd3;
      4'd7:        bank_of_mode = 3'd4;
      4'd11:       bank_of_mode = 3'd5;
      default:     bank_of_mode = BankNone;
    endcase
  endfunction

  function automatic logic [3:0] exc_mode(input logic [2:0] t);
    case (t)
      3'd0, 3'd2: exc_mode = 4'd3;
      3'd1:       exc_mode = 4'd11;
      3'd3, 3'd4: exc_mode = 4'd7;
      3'd6:       exc_mode = 4'd2;
      3'd7:       exc_mode = 4'd1;
      default:    exc_mode = 4'd0;
    endcase
  endfunction

  function automatic logic [DataW-1:0] exc_disable(input logic [2:0] t);
    case (t)
      3'd0, 3'd7:       exc_disable = 32'hC0;
      3'd2, 3'd6:       exc_disable = 32'h80;
      default:          exc_disable = 32'h0;
    endcase
  endfunction

endpackage

### hw/rtl/brms_ctrl.sv
// Handshake controller: accepts one transaction, holds the result register valid.
// Depends on brms_pkg.
module brms_ctrl import brms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic [DataW-1:0] value_i,
  input  logic [2:0]       exc_type_i,
  input  logic [4:0]       reg_index_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output brms_cmd_t        cmd_o
);

  localparam logic StEmpty = 1'b0;
  localparam logic StFull  = 1'b1;

  logic state_q, state_d;
  logic take;

  // A new event may enter when the result slot is empty or being drained
  assign in_stall_o = (state_q == StFull) && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StEmpty: if (take) state_d = StFull;
      StFull:  if (!out_stall_i && !take) state_d = StEmpty;
      default: state_d = StEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StEmpty;
    else         state_q <= state_d;
  end

  assign out_valid_o     = (state_q == StFull);
  assign cmd_o.load      = take;
  assign cmd_o.op        = opcode_i;
  assign cmd_o.value     = value_i;
  assign cmd_o.exc_type  = exc_type_i;
  assign cmd_o.reg_index = reg_index_i;

  // Held result stays valid while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  // No accept while a stalled result is held
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !cmd_o.load) else $error("overwrite");
  // Accept always yields a valid result next cycle
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o) else $error("result lost");

endmodule

### hw/rtl/brms_dp.sv
// Datapath: live registers, banks, status word and result register.
// Depends on brms_pkg.
module brms_dp import brms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  brms_cmd_t        cmd_i,
  output logic [DataW-1:0] status_out_o,
  output logic [DataW-1:0] pc_out_o,
  output logic [DataW-1:0] link_out_o,
  output logic [DataW-1:0] saved_status_out_o,
  output logic [DataW-1:0] read_data_o,
  output logic [1:0]       extra_cycles_o,
  output logic             fault_o
);

  logic [DataW-1:0] live_q [16];
  logic [DataW-1:0] live_d [16];
  logic [DataW-1:0] usr_q [5], usr_d [5];
  logic [DataW-1:0] fiq_q [5], fiq_d [5];
  logic [DataW-1:0] sl_q [12], sl_d [12];
  logic [DataW-1:0] sps_q [5], sps_d [5];
  logic [DataW-1:0] lsps_q, lsps_d, stat_q, stat_d;
  logic [DataW-1:0] rd_q, rd_d;
  logic [1:0]       cyc_q, cyc_d;
  logic             flt_q, flt_d;

  logic [2:0]       cur, nb;
  logic             do_swap;
  logic [DataW-1:0] old, sps_sel;

  // Event decode and bank swap
  always_comb begin
    live_d = live_q; usr_d = usr_q; fiq_d = fiq_q; sl_d = sl_q; sps_d = sps_q;
    lsps_d = lsps_q; stat_d = stat_q;
    rd_d = '0; cyc_d = 2'd0; flt_d = 1'b0;
    cur = bank_of_mode(stat_q[3:0]);
    nb = BankNone; do_swap = 1'b0; old = stat_q;
    sps_sel = '0;
    case (cmd_i.op)
      OpWrStatus: begin
        nb = bank_of_mode(cmd_i.value[3:0]);
        if (nb == BankNone) flt_d = 1'b1;
        else begin
          stat_d = cmd_i.value; do_swap = 1'b1;
        end
      end
      OpRaise: begin
        if (cmd_i.exc_type == ExcReserved) flt_d = 1'b1;
        else begin
          nb = bank_of_mode(exc_mode(cmd_i.exc_type)); do_swap = 1'b1;
          old = (stat_q & ~ThumbBit) | exc_disable(cmd_i.exc_type);
          stat_d = (old & ModeClear) | ({28'd0, exc_mode(cmd_i.exc_type)} + ModeBit4);
          cyc_d = 2'd2;
        end
      end
      OpReturn: begin
        nb = bank_of_mode(lsps_q[3:0]);
        if (nb == BankNone) flt_d = 1'b1;
        else begin
          stat_d = lsps_q; do_swap = 1'b1; cyc_d = 2'd2;
        end
      end
      OpRdReg: begin
        if (!cmd_i.reg_index[4]) rd_d = live_q[cmd_i.reg_index[3:0]];
        else if (cmd_i.reg_index == SpsrIndex) rd_d = lsps_q;
      end
      OpWrReg: begin
        if (!cmd_i.reg_index[4]) live_d[cmd_i.reg_index[3:0]] = cmd_i.value;
        else if (cmd_i.reg_index == SpsrIndex && cur != BankUsr) lsps_d = cmd_i.value;
      end
      default: ;
    endcase
    if (do_swap && cur != nb && cur != BankNone) begin
      if (cur == BankFiq) begin
        for (int i = 0; i < 5; i++) begin
          fiq_d[i] = live_q[8+i]; live_d[8+i] = usr_q[i];
        end
      end else if (nb == BankFiq) begin
        for (int i = 0; i < 5; i++) begin
          usr_d[i] = live_q[8+i]; live_d[8+i] = fiq_q[i];
        end
      end
      sl_d[{cur, 1'b0}] = live_q[13];
      sl_d[{cur, 1'b1}] = live_q[14];
      live_d[13] = sl_q[{nb, 1'b0}];
      live_d[14] = sl_q[{nb, 1'b1}];
      if (cur != BankUsr) sps_d[cur - 3'd1] = lsps_q;
      if (nb != BankUsr) sps_sel = sps_q[nb - 3'd1];
      lsps_d = sps_sel;
    end
    if (cmd_i.op == OpRaise && cmd_i.exc_type != ExcReserved) begin
      if (nb != BankUsr) lsps_d = stat_q;
      live_d[14] = cmd_i.value;
      live_d[15] = {27'd0, cmd_i.exc_type, 2'b00};
    end
    if (cmd_i.op == OpReturn && nb != BankNone) live_d[15] = cmd_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) live_q[i] <= '0;
      for (int i = 0; i < 5; i++) begin
        usr_q[i] <= '0; fiq_q[i] <= '0; sps_q[i] <= '0;
      end
      for (int i = 0; i < 12; i++) sl_q[i] <= '0;
      lsps_q <= '0; stat_q <= StatusRst;
    end else if (cmd_i.load) begin
      live_q <= live_d; usr_q <= usr_d; fiq_q <= fiq_d; sl_q <= sl_d; sps_q <= sps_d;
      lsps_q <= lsps_d; stat_q <= stat_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= rd_d; cyc_q <= cyc_d; flt_q <= flt_d;
    end
  end

  assign status_out_o       = stat_q;
  assign pc_out_o           = live_q[15];
  assign link_out_o         = live_q[14];
  assign saved_status_out_o = lsps_q;
  assign read_data_o        = rd_q;
  assign extra_cycles_o     = cyc_q;
  assign fault_o            = flt_q;

  // Status mode always decodes to a valid bank
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_of_mode(stat_q[3:0]) != BankNone) else $error("bad mode");
  // User bank never holds a saved status
  a_usr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_of_mode(stat_q[3:0]) == BankUsr |-> lsps_q == '0) else $error("usr spsr");
  // Fault and extra cycles are exclusive
  a_flt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !(flt_q && cyc_q != 2'd0)) else $error("fault with cycles");

endmodule

### hw/rtl/banked_register_mode_switch.sv
// Banked register file with processor modes and exception entry.
// Channels: input events on in_valid_i/in_stall_o carrying opcode, value,
// exception type and register index; results on out_valid_o/out_stall_i.
// Each accepted transaction yields one result in the next cycle, holding the
// status word, PC, link, saved status, read data, extra cycles and fault.
// Throughput: one transaction per cycle unless a held result is stalled; all
// bank moves are a single parallel register copy in the datapath.
// While the receiver stalls a held result, input stalls too; the result and
// the architectural state stay unchanged until it is taken.
// Reset zeroes live registers, banks and saved status and sets the status word to
// 0xD3 (supervisor, IRQ and FIQ disabled); no result is pending after reset.
// Depends on brms_pkg, brms_ctrl, brms_dp.
module banked_register_mode_switch import brms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       opcode_i,
  input  logic [DataW-1:0] value_i,
  input  logic [2:0]       exc_type_i,
  input  logic [4:0]       reg_index_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] status_out_o,
  output logic [DataW-1:0] pc_out_o,
  output logic [DataW-1:0] link_out_o,
  output logic [DataW-1:0] saved_status_out_o,
  output logic [DataW-1:0] read_data_o,
  output logic [1:0]       extra_cycles_o,
  output logic             fault_o
);

  brms_cmd_t cmd;

  brms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .value_i,
    .exc_type_i, .reg_index_i, .out_valid_o, .out_stall_i, .cmd_o(cmd)
  );

  brms_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_out_o, .pc_out_o, .link_out_o,
    .saved_status_out_o, .read_data_o, .extra_cycles_o, .fault_o
  );

endmodule
